[src/sfr_pkg.sv]
// Shared types, constants and the type code letter table of the sentence frame receiver.
`timescale 1ns / 1ps

package sfr_pkg;

  localparam int unsigned KIND_COUNT = 10;
  localparam int unsigned KIND_W = 4;
  localparam int unsigned LEN_W = 16;

  localparam logic [7:0] START_BYTE = 8'h24;
  localparam logic [LEN_W-1:0] MIN_FRAME = 16'd8;
  localparam logic [LEN_W-1:0] FRAME_MAX = 16'd1024;
  localparam logic [LEN_W-1:0] HEADER_BYTES = 16'd7;

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_BAD_SUM = 2'd1,
    ST_BAD_LEN = 2'd2
  } status_t;

  // Letters of the ten type codes, one row per kind.
  localparam logic [7:0] KIND_LETTERS [KIND_COUNT][4] = '{
    '{8'h47, 8'h4E, 8'h54, 8'h58},
    '{8'h47, 8'h4E, 8'h50, 8'h58},
    '{8'h47, 8'h4E, 8'h56, 8'h58},
    '{8'h44, 8'h57, 8'h58, 8'h58},
    '{8'h54, 8'h58, 8'h58, 8'h58},
    '{8'h49, 8'h43, 8'h58, 8'h58},
    '{8'h5A, 8'h4A, 8'h58, 8'h58},
    '{8'h53, 8'h4A, 8'h58, 8'h58},
    '{8'h42, 8'h42, 8'h58, 8'h58},
    '{8'h46, 8'h4B, 8'h58, 8'h58}
  };

  typedef struct packed {
    logic [KIND_COUNT-1:0] keep;
    logic [KIND_W-1:0]     first_kind;
  } match_t;

endpackage

[src/sentence_frame_receiver.sv]
// Top level of the sentence frame receiver: input register, frame parser and result register.
// A result word is registered when the parser takes the byte ending or rejecting a frame.
// One byte word is accepted every cycle while no result word waits on out_tready.
// A stalled result word blocks the input as soon as the input register holds a byte.
// Synchronous active-low reset returns the parser to the hunt and empties both registers.
`timescale 1ns / 1ps

module sentence_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [3:0] frame_kind, [19:4] frame_length, [21:20] status
);
  import sfr_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_CODE,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_BODY
  } phase_t;

  logic                  in_valid_r, in_valid_nxt;
  logic [7:0]            in_byte_r, in_byte_nxt;
  phase_t                phase_r, phase_nxt;
  logic [KIND_COUNT-1:0] cand_r, cand_nxt;
  logic [KIND_W-1:0]     kind_r, kind_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [LEN_W-1:0]      pos_r, pos_nxt;
  logic [7:0]            xor_r, xor_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]     out_kind_r, out_kind_nxt;
  logic [LEN_W-1:0]      out_len_r, out_len_nxt;
  status_t               out_status_r, out_status_nxt;

  logic             proc_en;
  logic [1:0]       slot;
  match_t           match;
  logic [LEN_W-1:0] full_len;
  logic [LEN_W:0]   pos_inc;

  assign proc_en   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proc_en;
  assign slot      = pos_r[1:0] - 2'd1;
  assign full_len  = {len_r[LEN_W-1:8], in_byte_r};
  assign pos_inc   = {1'b0, pos_r} + 17'd1;

  sfr_kind_match u_match (
    .candidates (cand_r),
    .slot       (slot),
    .rx_byte    (in_byte_r),
    .match      (match)
  );

  always_comb begin
    in_valid_nxt   = in_valid_r;
    in_byte_nxt    = in_byte_r;
    phase_nxt      = phase_r;
    cand_nxt       = cand_r;
    kind_nxt       = kind_r;
    len_nxt        = len_r;
    pos_nxt        = pos_r;
    xor_nxt        = xor_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_kind_nxt   = out_kind_r;
    out_len_nxt    = out_len_r;
    out_status_nxt = out_status_r;

    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
      in_byte_nxt  = in_tdata;
    end else if (proc_en) begin
      in_valid_nxt = 1'b0;
    end

    if (proc_en) begin
      case (phase_r)
        PH_CODE: begin
          if (match.keep == '0) begin
            cand_nxt = '1;
            if (in_byte_r == START_BYTE) begin
              phase_nxt = PH_CODE;
              kind_nxt  = '0;
              len_nxt   = '0;
              pos_nxt   = 16'd1;
              xor_nxt   = START_BYTE;
            end else begin
              phase_nxt = PH_HUNT;
              pos_nxt   = '0;
              xor_nxt   = '0;
            end
          end else begin
            cand_nxt = match.keep;
            xor_nxt  = xor_r ^ in_byte_r;
            pos_nxt  = pos_inc[LEN_W-1:0];
            if (slot == 2'd3) begin
              kind_nxt  = match.first_kind;
              phase_nxt = PH_LEN_HI;
            end
          end
        end
        PH_LEN_HI: begin
          len_nxt   = {in_byte_r, 8'd0};
          xor_nxt   = xor_r ^ in_byte_r;
          pos_nxt   = pos_inc[LEN_W-1:0];
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_nxt = full_len;
          xor_nxt = xor_r ^ in_byte_r;
          pos_nxt = HEADER_BYTES;
          if (full_len < MIN_FRAME || full_len > FRAME_MAX) begin
            phase_nxt      = PH_HUNT;
            cand_nxt       = '1;
            pos_nxt        = '0;
            xor_nxt        = '0;
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = kind_r;
            out_len_nxt    = full_len;
            out_status_nxt = ST_BAD_LEN;
          end else begin
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          if (pos_inc >= {1'b0, len_r}) begin
            phase_nxt      = PH_HUNT;
            cand_nxt       = '1;
            pos_nxt        = '0;
            xor_nxt        = '0;
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = kind_r;
            out_len_nxt    = len_r;
            out_status_nxt = (in_byte_r == xor_r) ? ST_GOOD : ST_BAD_SUM;
          end else begin
            xor_nxt = xor_r ^ in_byte_r;
            pos_nxt = pos_inc[LEN_W-1:0];
          end
        end
        default: begin
          cand_nxt = '1;
          if (in_byte_r == START_BYTE) begin
            phase_nxt = PH_CODE;
            kind_nxt  = '0;
            len_nxt   = '0;
            pos_nxt   = 16'd1;
            xor_nxt   = START_BYTE;
          end else begin
            phase_nxt = PH_HUNT;
            pos_nxt   = '0;
            xor_nxt   = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      phase_r     <= PH_HUNT;
      cand_r      <= '1;
      kind_r      <= '0;
      len_r       <= '0;
      pos_r       <= '0;
      xor_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      phase_r     <= phase_nxt;
      cand_r      <= cand_nxt;
      kind_r      <= kind_nxt;
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      xor_r       <= xor_nxt;
      out_valid_r <= out_valid_nxt;
    end
    in_byte_r    <= in_byte_nxt;
    out_kind_r   <= out_kind_nxt;
    out_len_r    <= out_len_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_status_r, out_len_r, out_kind_r};

endmodule

[src/sfr_kind_match.sv]
// Type code matcher: narrows the candidate kinds by one letter and picks the lowest survivor.
`timescale 1ns / 1ps

module sfr_kind_match (
  input  logic [sfr_pkg::KIND_COUNT-1:0] candidates,
  input  logic [1:0]                     slot,
  input  logic [7:0]                     rx_byte,
  output sfr_pkg::match_t                match
);
  import sfr_pkg::*;

  always_comb begin
    match.keep = '0;
    match.first_kind = '0;
    for (int k = 0; k < KIND_COUNT; k++) begin
      match.keep[k] = candidates[k] && (KIND_LETTERS[k][slot] == rx_byte);
    end
    for (int k = KIND_COUNT - 1; k >= 0; k--) begin
      if (match.keep[k]) begin
        match.first_kind = KIND_W'(k);
      end
    end
  end

endmodule

[src/sfr_checker.sv]
// Port-level assertions for the sentence frame receiver and their binding to the top level.
`timescale 1ns / 1ps

module sfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("Byte word changed or dropped while the input was stalled.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Result word changed or dropped while stalled.");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:0] <= 4'd9)
    else $error("Result word carries an unknown frame kind.");

  a_status_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[21:20] != 2'b11 && out_tdata[23:22] == 2'b00)
    else $error("Result word carries an unknown status or nonzero padding.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("Result word valid right after reset.");

endmodule

bind sentence_frame_receiver sfr_checker u_sfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
